// File: src/periodic_slot_scheduler_defines.svh
// Assertion macros shared by the scheduler sources.
// Each macro samples on the rising edge of clock and is quiet while reset is high.
`ifndef PERIODIC_SLOT_SCHEDULER_DEFINES_SVH
`define PERIODIC_SLOT_SCHEDULER_DEFINES_SVH

`define PSCH_ASSERT_ALWAYS(lbl, cond, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (cond)) else $error(msg);

`define PSCH_ASSERT_IMPLIES(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

`define PSCH_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// File: src/psch_pkg.sv
package psch_pkg;

   localparam int NUM_SLOTS      = 8;
   localparam int PERIOD_BITS    = 24;
   localparam int MAX_RESULTS    = 8;
   localparam int SLOT_BITS      = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
   localparam int COUNT_BITS     = $clog2(MAX_RESULTS + 1);
   localparam int INDEX_BITS     = 8;
   localparam int REQ_PERIOD_BITS = 24;
   localparam int MILLIS_BITS    = 32;

   typedef enum logic [1:0] {
      OP_TICK     = 2'd0,
      OP_ADD      = 2'd1,
      OP_RELEASE  = 2'd2,
      OP_DISPATCH = 2'd3
   } op_type;

   typedef logic [PERIOD_BITS-1:0] period_type;
   typedef logic [SLOT_BITS-1:0]   slot_type;

   // Command broadcast from the controller to every cell of the row.
   typedef struct packed {
      op_type                  op;
      logic [INDEX_BITS-1:0]   slot_index;
      logic                    handler_valid;
      period_type              period;
      logic                    shift;
      logic                    act;
      logic                    fire;
   } cell_cmd_type;

   // The request period is masked or widened to the stored width.
   function automatic period_type to_period(input logic [REQ_PERIOD_BITS-1:0] value);
      return period_type'(value);
   endfunction

endpackage

// File: src/psch_ifs.sv
interface psch_req_if;
   import psch_pkg::*;
   logic                         valid;
   logic                         ready;
   op_type                       opcode;
   logic [INDEX_BITS-1:0]        slot_index;
   logic                         handler_valid;
   logic [REQ_PERIOD_BITS-1:0]   period;

   modport source (output valid, opcode, slot_index, handler_valid, period, input ready);
   modport sink   (input valid, opcode, slot_index, handler_valid, period, output ready);
endinterface

interface psch_rsp_if;
   import psch_pkg::*;
   logic                     valid;
   logic                     ready;
   logic                     fired;
   logic [INDEX_BITS-1:0]    fired_slot;
   logic                     last_result;
   logic [MILLIS_BITS-1:0]   millis_now;

   modport source (output valid, fired, fired_slot, last_result, millis_now, input ready);
   modport sink   (input valid, fired, fired_slot, last_result, millis_now, output ready);
endinterface

// File: src/psch_cell.sv
module psch_cell (
   input  logic                    clock,
   input  logic                    reset,
   input  psch_pkg::slot_type      cell_index,
   input  psch_pkg::cell_cmd_type  cmd,
   input  logic                    token_in,
   output logic                    token_out,
   output logic                    due
);
   import psch_pkg::*;

   logic       occ_ff, occ_in;
   period_type period_ff, period_in;
   period_type count_ff, count_in;
   logic       token_ff, token_in_nxt;
   logic       sel;
   logic       match;

   assign sel   = token_ff && cmd.act;
   assign match = (cmd.slot_index == INDEX_BITS'(cell_index));

   always_comb begin
      occ_in    = occ_ff;
      period_in = period_ff;
      count_in  = count_ff;
      if (sel) begin
         unique case (cmd.op)
            OP_TICK: begin
               if (occ_ff && (count_ff != '0)) begin
                  count_in = count_ff - 1'b1;
               end
            end
            OP_ADD: begin
               if (match) begin
                  occ_in    = cmd.handler_valid;
                  period_in = cmd.period;
                  count_in  = cmd.period;
               end
            end
            OP_RELEASE: begin
               if (match) begin
                  occ_in    = 1'b0;
                  period_in = '0;
                  count_in  = '0;
               end
            end
            OP_DISPATCH: begin
               if (cmd.fire) begin
                  count_in = period_ff;
               end
            end
         endcase
      end
   end

   assign token_in_nxt = cmd.shift ? token_in : token_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         occ_ff    <= 1'b0;
         period_ff <= '0;
         count_ff  <= '0;
         token_ff  <= 1'b0;
      end else begin
         occ_ff    <= occ_in;
         period_ff <= period_in;
         count_ff  <= count_in;
         token_ff  <= token_in_nxt;
      end
   end

   assign token_out = token_ff;
   assign due       = occ_ff && (period_ff != '0) && (count_ff == '0);

endmodule

// File: src/psch_ctrl.sv
`include "periodic_slot_scheduler_defines.svh"

module psch_ctrl (
   input  logic                             clock,
   input  logic                             reset,
   psch_req_if.sink                         req_ch,
   psch_rsp_if.source                       rsp_ch,
   input  logic [psch_pkg::NUM_SLOTS-1:0]   due_vec,
   output psch_pkg::cell_cmd_type           cmd,
   output logic                             token_start
);
   import psch_pkg::*;

   typedef enum logic [2:0] {
      ST_IDLE = 3'b001,
      ST_SCAN = 3'b010,
      ST_DONE = 3'b100
   } state_type;

   state_type                   state_ff, state_in;
   op_type                      op_ff;
   logic [INDEX_BITS-1:0]       index_ff;
   logic                        hv_ff;
   period_type                  period_ff;
   logic [NUM_SLOTS-1:0]        pending_ff, pending_in;
   slot_type                    pos_ff, pos_in;
   logic [COUNT_BITS-1:0]       count_ff, count_in;
   logic [MILLIS_BITS-1:0]      millis_ff, millis_in;

   logic                        out_valid_ff, out_valid_in;
   logic                        out_fired_ff;
   logic [INDEX_BITS-1:0]       out_slot_ff;
   logic                        out_last_ff;
   logic [MILLIS_BITS-1:0]      out_millis_ff;

   logic                        accept;
   logic                        can_emit;
   logic                        is_due;
   logic                        stall;
   logic                        step;
   logic                        emit;
   logic                        emit_fired;
   logic [INDEX_BITS-1:0]       emit_slot;
   logic                        emit_last;
   logic [NUM_SLOTS-1:0]        later;

   assign req_ch.ready = (state_ff == ST_IDLE);
   assign accept       = req_ch.valid && req_ch.ready;
   assign can_emit     = !out_valid_ff || rsp_ch.ready;
   assign later        = pending_ff >> 1;

   // A slot is reported only while the per-request result budget lasts.
   assign is_due = (state_ff == ST_SCAN) && (op_ff == OP_DISPATCH) && pending_ff[0]
                   && (count_ff < COUNT_BITS'(MAX_RESULTS));
   assign stall  = is_due && !can_emit;
   assign step   = (state_ff == ST_SCAN) && !stall;

   always_comb begin
      state_in   = state_ff;
      pending_in = pending_ff;
      pos_in     = pos_ff;
      count_in   = count_ff;
      millis_in  = millis_ff;
      emit       = 1'b0;
      emit_fired = 1'b0;
      emit_slot  = '0;
      emit_last  = 1'b1;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               state_in   = ST_SCAN;
               pending_in = due_vec;
               pos_in     = '0;
               count_in   = '0;
               if (req_ch.opcode == OP_TICK) begin
                  millis_in = millis_ff + 1'b1;
               end
            end
         end
         ST_SCAN: begin
            if (step) begin
               pending_in = later;
               pos_in     = pos_ff + 1'b1;
               if (is_due) begin
                  count_in   = count_ff + 1'b1;
                  emit       = 1'b1;
                  emit_fired = 1'b1;
                  emit_slot  = INDEX_BITS'(pos_ff);
                  emit_last  = (count_ff == COUNT_BITS'(MAX_RESULTS - 1)) || (later == '0);
               end
               if (pos_ff == SLOT_BITS'(NUM_SLOTS - 1)) begin
                  state_in = ST_DONE;
               end
            end
         end
         ST_DONE: begin
            if (count_ff != '0) begin
               state_in = ST_IDLE;
            end else if (can_emit) begin
               emit     = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      out_valid_in = out_valid_ff;
      if (emit) begin
         out_valid_in = 1'b1;
      end else if (rsp_ch.ready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         pending_ff   <= '0;
         pos_ff       <= '0;
         count_ff     <= '0;
         millis_ff    <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         pending_ff   <= pending_in;
         pos_ff       <= pos_in;
         count_ff     <= count_in;
         millis_ff    <= millis_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         op_ff     <= req_ch.opcode;
         index_ff  <= req_ch.slot_index;
         hv_ff     <= req_ch.handler_valid;
         period_ff <= to_period(req_ch.period);
      end
      if (emit) begin
         out_fired_ff  <= emit_fired;
         out_slot_ff   <= emit_slot;
         out_last_ff   <= emit_last;
         out_millis_ff <= millis_ff;
      end
   end

   always_comb begin
      cmd.op            = op_ff;
      cmd.slot_index    = index_ff;
      cmd.handler_valid = hv_ff;
      cmd.period        = period_ff;
      cmd.shift         = accept || step;
      cmd.act           = step;
      cmd.fire          = is_due;
   end
   assign token_start = accept;

   assign rsp_ch.valid       = out_valid_ff;
   assign rsp_ch.fired       = out_fired_ff;
   assign rsp_ch.fired_slot  = out_slot_ff;
   assign rsp_ch.last_result = out_last_ff;
   assign rsp_ch.millis_now  = out_millis_ff;

   `PSCH_ASSERT_ALWAYS(a_count_bound, count_ff <= COUNT_BITS'(MAX_RESULTS), "result budget exceeded")
   `PSCH_ASSERT_NEXT(a_accept_scan, accept, state_ff == ST_SCAN, "request did not start a scan")
   `PSCH_ASSERT_NEXT(a_stall_hold, stall, $stable(pos_ff) && $stable(pending_ff), "scan moved while stalled")
   `PSCH_ASSERT_IMPLIES(a_emit_room, emit, can_emit, "result written over an untaken one")

endmodule

// File: src/periodic_slot_scheduler.sv
// Periodic slot scheduler: a row of slot cells visited by a token, one slot per cycle.
// Each request runs in steps: the accept, a visit to each slot in turn, then a finishing step.
// Results are registered and appear in the cycle after the slot that causes them; a request
// with no fired slot gives its single result once the scan is done. A stalled result holds the scan.
// Synchronous active-high reset clears all slots, the tick counter and the result valid flag.
`include "periodic_slot_scheduler_defines.svh"

module periodic_slot_scheduler (
   input  logic          clock,
   input  logic          reset,
   psch_req_if.sink      req_ch,
   psch_rsp_if.source    rsp_ch
);
   import psch_pkg::*;

   cell_cmd_type            cmd;
   logic                    token_start;
   logic [NUM_SLOTS-1:0]    tokens;
   logic [NUM_SLOTS-1:0]    due_vec;

   psch_ctrl u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .req_ch      (req_ch),
      .rsp_ch      (rsp_ch),
      .due_vec     (due_vec),
      .cmd         (cmd),
      .token_start (token_start)
   );

   for (genvar i = 0; i < NUM_SLOTS; i++) begin : g_cell
      logic token_feed;
      if (i == 0) begin : g_head
         assign token_feed = token_start;
      end else begin : g_body
         assign token_feed = tokens[i-1];
      end
      psch_cell u_cell (
         .clock      (clock),
         .reset      (reset),
         .cell_index (SLOT_BITS'(i)),
         .cmd        (cmd),
         .token_in   (token_feed),
         .token_out  (tokens[i]),
         .due        (due_vec[i])
      );
   end

   `PSCH_ASSERT_ALWAYS(a_one_token, $onehot0(tokens), "more than one slot holds the token")

endmodule
